// ===== src/three_phase_pair_angle_weights_defines.svh =====
// assertion macros for the three-phase pair angle weights block
// no dependencies; included by the top level
`ifndef THREE_PHASE_PAIR_ANGLE_WEIGHTS_DEFINES_SVH
`define THREE_PHASE_PAIR_ANGLE_WEIGHTS_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define TPPAW_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent a fixed number of cycles later
`define TPPAW_ASSERT_DLY(lbl, clk, rst, ante, n, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##n (cons)) else $error(msg);

`endif

// ===== src/tppaw_pkg.sv =====
// shared types, constants and elaboration-time tables for the pair weight block
// no dependencies
package tppaw_pkg;

   localparam int FIELD_W      = 17;
   localparam int COORD_FRAC   = 16;
   localparam int COORD_W      = 22;
   localparam int QUOT_W       = 21;
   localparam int CORDIC_STEPS = 32;
   localparam int ANGLE_W      = 64;
   localparam int ZW           = 36;
   localparam int DIV_LAT      = QUOT_W + 1;
   localparam int ANG_LAT      = 5 + CORDIC_STEPS + 1;

   localparam logic [FIELD_W-1:0] CLAMP_RESET = 17'd64881;
   localparam logic [FIELD_W-1:0] FIELD_MAX   = 17'h1FFFF;
   localparam logic [17:0]        SQRT3_Q16   = 18'd113512;
   localparam logic [63:0]        INV_PI_Q32  = 64'd1367130551;
   localparam logic [QUOT_W-1:0]  COORD_SAT   = 21'h10_0000;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_ZERO_SUM  = 2'd1,
      STATUS_ZERO_DIST = 2'd2
   } status_type;

   typedef logic signed [COORD_W-1:0] coord_type;

   typedef struct packed {
      coord_type c0;
      coord_type c1;
      coord_type c2;
   } point_type;

   typedef logic [31:0] step_type;
   typedef step_type step_table_type [CORDIC_STEPS];

   // atan(2^-i)/pi in Q32, built from a truncated alternating series
   function automatic step_table_type build_steps();
      step_table_type tbl;
      logic signed [63:0] acc;
      logic [63:0] term;
      logic [63:0] prod;
      int e;
      logic done;
      tbl[0] = 32'h4000_0000;
      for (int i = 1; i < CORDIC_STEPS; i++) begin
         acc = '0;
         done = 1'b0;
         for (int k = 0; k < 64; k++) begin
            e = 62 - i * (2 * k + 1);
            if (e < 0) done = 1'b1;
            if (!done) begin
               term = (64'd1 << e) / 64'(2 * k + 1);
               if (k % 2 == 1) acc = acc - signed'(term);
               else acc = acc + signed'(term);
            end
         end
         prod = (64'(acc) >> 30) * INV_PI_Q32;
         tbl[i] = prod[63:32];
      end
      return tbl;
   endfunction

   localparam step_table_type STEP_ANGLE = build_steps();

   // arithmetic shift right rounding toward zero
   function automatic logic signed [ANGLE_W-1:0] shr_tz(input logic signed [ANGLE_W-1:0] v,
                                                      input int s);
      logic signed [ANGLE_W-1:0] m;
      m = -v;
      if (v[ANGLE_W-1]) return -(signed'(m >> s));
      return signed'(v >> s);
   endfunction

endpackage

// ===== src/tppaw_div_lane.sv =====
// one pipelined restoring divider lane: magnitude * 2^16 / sum, saturated at 16.0
// depends on tppaw_pkg
module tppaw_div_lane #(
   parameter int DW = 18
) (
   input  logic                   clock,
   input  logic [DW-1:0]          num,
   input  logic [DW-1:0]          den,
   input  logic                   neg,
   output tppaw_pkg::coord_type   coord
);

   localparam int QW = tppaw_pkg::QUOT_W;
   localparam int HI = QW - tppaw_pkg::COORD_FRAC;

   logic [DW-1:0] rem_ff [QW];
   logic [DW-1:0] den_ff [QW];
   logic [QW-1:0] low_ff [QW];
   logic [QW-1:0] q_ff   [QW];
   logic          neg_ff [QW];
   logic          ovf_ff [QW];
   logic          ovf_in;
   logic [QW-1:0] mag;
   tppaw_pkg::coord_type coord_ff;

   // quotient would need more than the quotient bits
   assign ovf_in = {{HI{1'b0}}, num} >= {den, {HI{1'b0}}};

   for (genvar s = 0; s < QW; s++) begin : g_stage
      logic [DW-1:0] src_rem;
      logic [DW-1:0] src_den;
      logic [QW-1:0] src_low;
      logic [QW-1:0] src_q;
      logic          src_neg;
      logic          src_ovf;
      logic [DW:0]   trial;
      logic          ge;
      if (s == 0) begin : g_first
         assign src_rem = num >> HI;
         assign src_den = den;
         assign src_low = {num[HI-1:0], {tppaw_pkg::COORD_FRAC{1'b0}}};
         assign src_q   = '0;
         assign src_neg = neg;
         assign src_ovf = ovf_in;
      end else begin : g_next
         assign src_rem = rem_ff[s-1];
         assign src_den = den_ff[s-1];
         assign src_low = low_ff[s-1];
         assign src_q   = q_ff[s-1];
         assign src_neg = neg_ff[s-1];
         assign src_ovf = ovf_ff[s-1];
      end
      assign trial = {src_rem, src_low[QW-1]};
      assign ge    = trial >= {1'b0, src_den};
      always_ff @(posedge clock) begin
         rem_ff[s] <= ge ? DW'(trial - {1'b0, src_den}) : trial[DW-1:0];
         den_ff[s] <= src_den;
         low_ff[s] <= {src_low[QW-2:0], 1'b0};
         q_ff[s]   <= {src_q[QW-2:0], ge};
         neg_ff[s] <= src_neg;
         ovf_ff[s] <= src_ovf;
      end
   end

   always_comb begin
      mag = q_ff[QW-1];
      if (ovf_ff[QW-1] || mag > tppaw_pkg::COORD_SAT) mag = tppaw_pkg::COORD_SAT;
   end

   always_ff @(posedge clock) begin
      if (neg_ff[QW-1]) coord_ff <= -signed'(tppaw_pkg::COORD_W'(mag));
      else coord_ff <= signed'(tppaw_pkg::COORD_W'(mag));
   end

   assign coord = coord_ff;

endmodule

// ===== src/tppaw_angle_lane.sv =====
// one vertex angle lane: dot and cross terms, scaled atan2 by cordic, rounded weight
// depends on tppaw_pkg
module tppaw_angle_lane #(
   parameter int FRAC_BITS = 16
) (
   input  logic                  clock,
   input  tppaw_pkg::point_type  p,
   input  tppaw_pkg::point_type  q,
   input  tppaw_pkg::point_type  r,
   output logic [tppaw_pkg::FIELD_W-1:0] weight
);

   localparam int DIFF_W = tppaw_pkg::COORD_W + 1;
   localparam int PROD_W = 2 * DIFF_W;
   localparam int SUM_W  = PROD_W + 3;
   localparam int AW     = tppaw_pkg::ANGLE_W;
   localparam int ZW     = tppaw_pkg::ZW;
   localparam int NS     = tppaw_pkg::CORDIC_STEPS;
   localparam int SH     = 32 - FRAC_BITS;
   localparam logic [33:0] RND = (34'd1 << SH) >> 1;
   localparam logic signed [ZW-1:0] Z_MAX  = ZW'(64'd1 << 32);
   localparam logic signed [ZW-1:0] Z_HALF = ZW'(64'd1 << 31);

   tppaw_pkg::coord_type pa [3];
   tppaw_pkg::coord_type qa [3];
   tppaw_pkg::coord_type ra [3];

   logic signed [DIFF_W-1:0] u_ff [3];
   logic signed [DIFF_W-1:0] w_ff [3];
   logic signed [PROD_W-1:0] dp_ff [3];
   logic signed [PROD_W-1:0] cp_ff [6];
   logic signed [SUM_W-1:0]  dot_ff;
   logic signed [SUM_W-1:0]  cabs_ff;
   logic signed [SUM_W-1:0]  cs;
   logic signed [AW-1:0]     xp_ff;
   logic signed [AW-1:0]     yv_ff;
   logic signed [AW-1:0]     xs;
   logic signed [AW-1:0]     cx_ff [NS+1];
   logic signed [AW-1:0]     cy_ff [NS+1];
   logic signed [ZW-1:0]     cz_ff [NS+1];
   logic [32:0]              zc;
   logic [33:0]              rv;
   logic [33:0]              vv;
   logic [tppaw_pkg::FIELD_W-1:0] weight_ff;

   assign pa = '{p.c0, p.c1, p.c2};
   assign qa = '{q.c0, q.c1, q.c2};
   assign ra = '{r.c0, r.c1, r.c2};

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         u_ff[i] <= DIFF_W'(qa[i]) - DIFF_W'(pa[i]);
         w_ff[i] <= DIFF_W'(ra[i]) - DIFF_W'(pa[i]);
         dp_ff[i] <= PROD_W'(u_ff[i]) * PROD_W'(w_ff[i]);
      end
      cp_ff[0] <= PROD_W'(u_ff[1]) * PROD_W'(w_ff[2]);
      cp_ff[1] <= PROD_W'(u_ff[2]) * PROD_W'(w_ff[1]);
      cp_ff[2] <= PROD_W'(u_ff[2]) * PROD_W'(w_ff[0]);
      cp_ff[3] <= PROD_W'(u_ff[0]) * PROD_W'(w_ff[2]);
      cp_ff[4] <= PROD_W'(u_ff[0]) * PROD_W'(w_ff[1]);
      cp_ff[5] <= PROD_W'(u_ff[1]) * PROD_W'(w_ff[0]);
   end

   assign cs = (SUM_W'(cp_ff[0]) - SUM_W'(cp_ff[1])) + (SUM_W'(cp_ff[2]) - SUM_W'(cp_ff[3]))
             + (SUM_W'(cp_ff[4]) - SUM_W'(cp_ff[5]));

   always_ff @(posedge clock) begin
      dot_ff  <= SUM_W'(dp_ff[0]) + SUM_W'(dp_ff[1]) + SUM_W'(dp_ff[2]);
      cabs_ff <= cs[SUM_W-1] ? -cs : cs;
      xp_ff   <= AW'(dot_ff) * signed'({1'b0, tppaw_pkg::SQRT3_Q16});
      yv_ff   <= AW'(cabs_ff) << 14;
   end

   assign xs = tppaw_pkg::shr_tz(xp_ff, 2);

   // negative x: quarter turn first, angle starts at one half
   always_ff @(posedge clock) begin
      if (xs[AW-1]) begin
         cx_ff[0] <= yv_ff;
         cy_ff[0] <= -xs;
         cz_ff[0] <= Z_HALF;
      end else begin
         cx_ff[0] <= xs;
         cy_ff[0] <= yv_ff;
         cz_ff[0] <= '0;
      end
   end

   for (genvar s = 0; s < NS; s++) begin : g_cordic
      logic signed [AW-1:0] dx;
      logic signed [AW-1:0] dy;
      logic signed [ZW-1:0] da;
      assign dx = tppaw_pkg::shr_tz(cy_ff[s], s);
      assign dy = tppaw_pkg::shr_tz(cx_ff[s], s);
      assign da = signed'(ZW'(tppaw_pkg::STEP_ANGLE[s]));
      always_ff @(posedge clock) begin
         if (cy_ff[s] > 0) begin
            cx_ff[s+1] <= cx_ff[s] + dx;
            cy_ff[s+1] <= cy_ff[s] - dy;
            cz_ff[s+1] <= cz_ff[s] + da;
         end else begin
            cx_ff[s+1] <= cx_ff[s] - dx;
            cy_ff[s+1] <= cy_ff[s] + dy;
            cz_ff[s+1] <= cz_ff[s] - da;
         end
      end
   end

   always_comb begin
      if (cz_ff[NS][ZW-1]) zc = '0;
      else if (cz_ff[NS] > Z_MAX) zc = 33'(Z_MAX);
      else zc = 33'(cz_ff[NS]);
      rv = {1'b0, zc} + RND;
      vv = rv >> SH;
   end

   always_ff @(posedge clock) begin
      if (vv > 34'(tppaw_pkg::FIELD_MAX)) weight_ff <= tppaw_pkg::FIELD_MAX;
      else weight_ff <= vv[tppaw_pkg::FIELD_W-1:0];
   end

   assign weight = weight_ff;

endmodule

// ===== src/three_phase_pair_angle_weights.sv =====
// top level: phase clamp and adjust, six divider lanes, three angle lanes, merge
// depends on tppaw_pkg, tppaw_div_lane, tppaw_angle_lane and the defines header
//
//  channel   ports                          flow control
//  --------  -----------------------------  ------------------------------
//  request   start, busy, req_frac_*        taken when start and not busy
//  response  rsp_valid, rsp_weight_*, stat  one-cycle strobe, no back-pressure
//  csr       csr_wr_en, csr_wr_data         written on any cycle with enable
//
// one transaction per clock; busy is always low
// stages in order: 4 adjust stages, the 21-step divider
//   pipeline plus its output register, the 32-step cordic angle pipeline, output
// reset clears the in-flight valid bits and loads clamp_limit with 0.99
`include "three_phase_pair_angle_weights_defines.svh"
module three_phase_pair_angle_weights #(
   parameter int FRAC_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [16:0] req_frac_zero,
   input  logic [16:0] req_frac_one,
   input  logic [16:0] req_frac_two,
   input  logic        csr_wr_en,
   input  logic [16:0] csr_wr_data,
   output logic        rsp_valid,
   output logic [16:0] rsp_weight_zero_one,
   output logic [16:0] rsp_weight_zero_two,
   output logic [16:0] rsp_weight_one_two,
   output logic [1:0]  rsp_status
);

   localparam int PW  = FRAC_BITS + 3;
   localparam int DW  = PW - 1;
   localparam int FW  = tppaw_pkg::FIELD_W;
   localparam int CW  = (PW > FW ? PW : FW) + 1;
   localparam int LAT = 5 + tppaw_pkg::DIV_LAT + tppaw_pkg::ANG_LAT;
   localparam logic signed [PW-1:0] ONE = {2'b00, 1'b1, {FRAC_BITS{1'b0}}};

   logic [FW-1:0]          clamp_ff;
   logic [LAT-1:0]         vld_ff;
   logic                   accept;
   logic [FW-1:0]          fin [3];
   logic signed [PW-1:0]   psat [3];
   logic signed [PW-1:0]   lsat;
   logic signed [PW-1:0]   ps_ff [3];
   logic signed [PW-1:0]   lim_ff;
   logic [2:0]             hit;
   logic signed [PW-1:0]   pm [3];
   logic signed [PW-1:0]   pm_ff [3];
   logic signed [PW-1:0]   def_ff;
   logic [2:0]             hit_ff;
   logic signed [PW-1:0]   half;
   logic signed [PW-1:0]   pa_ff [3];
   logic signed [PW-1:0]   sum [3];
   logic signed [PW-1:0]   lnum [6];
   logic signed [PW-1:0]   lden [6];
   logic [DW-1:0]          mag_ff [6];
   logic [DW-1:0]          den_ff [6];
   logic                   neg_ff [6];
   logic                   bad_ff;
   logic                   bad_pipe_ff [tppaw_pkg::DIV_LAT];
   tppaw_pkg::coord_type   coord [6];
   tppaw_pkg::point_type   v01, v02, v12;
   logic                   same;
   tppaw_pkg::status_type  st_now;
   tppaw_pkg::status_type  st_pipe_ff [tppaw_pkg::ANG_LAT];
   logic [FW-1:0]          w01, w02, w12;
   logic [FW-1:0]          w01_ff, w02_ff, w12_ff;
   tppaw_pkg::status_type  st_ff;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         clamp_ff <= tppaw_pkg::CLAMP_RESET;
         vld_ff   <= '0;
      end else begin
         if (csr_wr_en) clamp_ff <= csr_wr_data;
         vld_ff <= {vld_ff[LAT-2:0], accept};
      end
   end

   // saturate inputs and limit at one
   assign fin = '{req_frac_zero, req_frac_one, req_frac_two};
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (CW'(fin[i]) > CW'(ONE)) psat[i] = ONE;
         else psat[i] = signed'(PW'(fin[i]));
      end
      if (CW'(clamp_ff) > CW'(ONE)) lsat = ONE;
      else lsat = signed'(PW'(clamp_ff));
   end

   always_ff @(posedge clock) begin
      ps_ff  <= psat;
      lim_ff <= lsat;
   end

   // first phase over the limit is clamped
   always_comb begin
      hit[0] = ps_ff[0] > lim_ff;
      hit[1] = !hit[0] && ps_ff[1] > lim_ff;
      hit[2] = !hit[0] && !hit[1] && ps_ff[2] > lim_ff;
      for (int i = 0; i < 3; i++) pm[i] = hit[i] ? lim_ff : ps_ff[i];
   end

   always_ff @(posedge clock) begin
      pm_ff  <= pm;
      hit_ff <= hit;
      def_ff <= ONE - pm[0] - pm[1] - pm[2];
   end

   // half deficit, truncated toward zero
   assign half = (def_ff + signed'(PW'(def_ff[PW-1]))) >>> 1;

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         if (hit_ff != 3'b000 && !hit_ff[i]) pa_ff[i] <= pm_ff[i] + half;
         else pa_ff[i] <= pm_ff[i];
      end
   end

   always_comb begin
      sum[0] = pa_ff[0] + pa_ff[1];
      sum[1] = pa_ff[0] + pa_ff[2];
      sum[2] = pa_ff[1] + pa_ff[2];
      lnum = '{pa_ff[0], pa_ff[1], pa_ff[0], pa_ff[2], pa_ff[1], pa_ff[2]};
      lden = '{sum[0], sum[0], sum[1], sum[1], sum[2], sum[2]};
   end

   always_ff @(posedge clock) begin
      bad_ff <= sum[0] <= 0 || sum[1] <= 0 || sum[2] <= 0;
      for (int i = 0; i < 6; i++) begin
         neg_ff[i] <= lnum[i][PW-1];
         mag_ff[i] <= lnum[i][PW-1] ? DW'(-lnum[i]) : DW'(lnum[i]);
         den_ff[i] <= lden[i][DW-1:0];
      end
   end

   for (genvar i = 0; i < 6; i++) begin : g_div
      tppaw_div_lane #(.DW(DW)) u_div (
         .clock (clock),
         .num   (mag_ff[i]),
         .den   (den_ff[i]),
         .neg   (neg_ff[i]),
         .coord (coord[i])
      );
   end

   always_ff @(posedge clock) begin
      bad_pipe_ff[0] <= bad_ff;
      for (int i = 1; i < tppaw_pkg::DIV_LAT; i++) bad_pipe_ff[i] <= bad_pipe_ff[i-1];
   end

   // merge lane results into the three pair points
   always_comb begin
      v01 = '{c0: coord[0], c1: coord[1], c2: '0};
      v02 = '{c0: coord[2], c1: '0, c2: coord[3]};
      v12 = '{c0: '0, c1: coord[4], c2: coord[5]};
      same = v01 == v02 || v01 == v12 || v02 == v12;
      if (bad_pipe_ff[tppaw_pkg::DIV_LAT-1]) st_now = tppaw_pkg::STATUS_ZERO_SUM;
      else if (same) st_now = tppaw_pkg::STATUS_ZERO_DIST;
      else st_now = tppaw_pkg::STATUS_OK;
   end

   tppaw_angle_lane #(.FRAC_BITS(FRAC_BITS)) u_ang01 (
      .clock (clock), .p (v01), .q (v02), .r (v12), .weight (w01)
   );
   tppaw_angle_lane #(.FRAC_BITS(FRAC_BITS)) u_ang02 (
      .clock (clock), .p (v02), .q (v01), .r (v12), .weight (w02)
   );
   tppaw_angle_lane #(.FRAC_BITS(FRAC_BITS)) u_ang12 (
      .clock (clock), .p (v12), .q (v01), .r (v02), .weight (w12)
   );

   always_ff @(posedge clock) begin
      st_pipe_ff[0] <= st_now;
      for (int i = 1; i < tppaw_pkg::ANG_LAT; i++) st_pipe_ff[i] <= st_pipe_ff[i-1];
   end

   always_ff @(posedge clock) begin
      st_ff <= st_pipe_ff[tppaw_pkg::ANG_LAT-1];
      if (st_pipe_ff[tppaw_pkg::ANG_LAT-1] == tppaw_pkg::STATUS_OK) begin
         w01_ff <= w01;
         w02_ff <= w02;
         w12_ff <= w12;
      end else begin
         w01_ff <= '0;
         w02_ff <= '0;
         w12_ff <= '0;
      end
   end

   assign rsp_valid           = vld_ff[LAT-1];
   assign rsp_weight_zero_one = w01_ff;
   assign rsp_weight_zero_two = w02_ff;
   assign rsp_weight_one_two  = w12_ff;
   assign rsp_status          = st_ff;

   `TPPAW_ASSERT_DLY(a_fixed_latency, clock, reset, accept, LAT, rsp_valid, "response missing after a transaction")
   `TPPAW_ASSERT_IMP(a_fault_zero, clock, reset, rsp_valid && rsp_status != tppaw_pkg::STATUS_OK, rsp_weight_zero_one == '0 && rsp_weight_zero_two == '0 && rsp_weight_one_two == '0, "nonzero weight with fault status")
   `TPPAW_ASSERT_IMP(a_status_code, clock, reset, rsp_valid, rsp_status == tppaw_pkg::STATUS_OK || rsp_status == tppaw_pkg::STATUS_ZERO_SUM || rsp_status == tppaw_pkg::STATUS_ZERO_DIST, "bad status code")

endmodule
